// ----- sv/vpc_pkg.sv -----
// Shared types and constants for the vertex projection, clip and viewport block.
// No dependencies; every other file depends on this package.
package vpc_pkg;

  localparam int POS_W          = 24;  // world coordinate width
  localparam int COEF_W         = 16;  // Q7.8 matrix coefficient
  localparam int ROW_W          = 64;  // one packed matrix row
  localparam int PROD_W         = 40;  // coefficient * coordinate
  localparam int CLIP_W         = 42;  // sum of four products
  localparam int NUM_W          = 43;  // numerator and denominator of the divide
  localparam int VP_W           = 14;  // viewport register width
  localparam int SIZE_W         = VP_W + 4;        // size in 1/16 pixel
  localparam int QUO_W          = SIZE_W;          // quotient never exceeds size
  localparam int DVD_W          = NUM_W + SIZE_W;  // dividend width
  localparam int SCR_W          = 19;  // screen coordinate width
  localparam int ADDR_W         = 6;   // eight 64-bit registers
  localparam int POS_FRAC_BITS_DEF = 12;

  localparam logic [SCR_W-1:0] SCREEN_MAX = {SCR_W{1'b1}};

  typedef enum logic [2:0] {
    REG_ROW0     = 3'd0,
    REG_ROW1     = 3'd1,
    REG_ROW2     = 3'd2,
    REG_ROW3     = 3'd3,
    REG_VP_LEFT  = 3'd4,
    REG_VP_TOP   = 3'd5,
    REG_VP_WIDTH = 3'd6,
    REG_VP_HGT   = 3'd7
  } reg_idx_t;

  // Register file contents as seen by the datapath
  typedef struct packed {
    logic [3:0][ROW_W-1:0] row;
    logic [VP_W-1:0]       left;
    logic [VP_W-1:0]       top;
    logic [VP_W-1:0]       width;
    logic [VP_W-1:0]       height;
  } cfg_t;

endpackage

// ----- sv/vpc_if.sv -----
// Valid/ready channel interfaces for point beats and screen result beats.
// Depends on vpc_pkg for field widths.
interface vpc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vpc_pkg::POS_W-1:0]    pos_x;
  logic signed [vpc_pkg::POS_W-1:0]    pos_y;
  logic signed [vpc_pkg::POS_W-1:0]    pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface vpc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         visible;
  logic [vpc_pkg::SCR_W-1:0]    screen_x;
  logic [vpc_pkg::SCR_W-1:0]    screen_y;
  modport source (output valid, visible, screen_x, screen_y, input ready);
  modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface

// ----- sv/vpc_cfg.sv -----
// APB-style configuration registers: four matrix rows and the viewport.
// Depends on vpc_pkg.
module vpc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [vpc_pkg::ROW_W-1:0]   pwdata,
  output logic [vpc_pkg::ROW_W-1:0]   prdata,
  output logic                        pready,
  output vpc_pkg::cfg_t               cfg
);
  import vpc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Write the addressed register in the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr) begin
      case (idx)
        REG_ROW0:     cfg_r.row[0] <= pwdata;
        REG_ROW1:     cfg_r.row[1] <= pwdata;
        REG_ROW2:     cfg_r.row[2] <= pwdata;
        REG_ROW3:     cfg_r.row[3] <= pwdata;
        REG_VP_LEFT:  cfg_r.left   <= pwdata[VP_W-1:0];
        REG_VP_TOP:   cfg_r.top    <= pwdata[VP_W-1:0];
        REG_VP_WIDTH: cfg_r.width  <= pwdata[VP_W-1:0];
        REG_VP_HGT:   cfg_r.height <= pwdata[VP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_ROW0:     prdata = cfg_r.row[0];
      REG_ROW1:     prdata = cfg_r.row[1];
      REG_ROW2:     prdata = cfg_r.row[2];
      REG_ROW3:     prdata = cfg_r.row[3];
      REG_VP_LEFT:  prdata = ROW_W'(cfg_r.left);
      REG_VP_TOP:   prdata = ROW_W'(cfg_r.top);
      REG_VP_WIDTH: prdata = ROW_W'(cfg_r.width);
      REG_VP_HGT:   prdata = ROW_W'(cfg_r.height);
      default:      prdata = '0;
    endcase
  end

endmodule

// ----- sv/vpc_clip.sv -----
// Matrix multiply and clip test: products, row sums, then clip compare.
// Three register stages. Depends on vpc_pkg.
module vpc_clip #(
  parameter int POS_FRAC_BITS = vpc_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [vpc_pkg::POS_W-1:0]   pos_x,
  input  logic signed [vpc_pkg::POS_W-1:0]   pos_y,
  input  logic signed [vpc_pkg::POS_W-1:0]   pos_z,
  input  vpc_pkg::cfg_t                      cfg,
  output logic                               out_valid,
  output logic                               visible,
  output logic [vpc_pkg::NUM_W-1:0]          num_x,
  output logic [vpc_pkg::NUM_W-1:0]          num_y,
  output logic [vpc_pkg::NUM_W-1:0]          den
);
  import vpc_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt [4][4];
  logic signed [PROD_W-1:0] prod_r   [4][4];
  logic signed [CLIP_W-1:0] clip_nxt [4];
  logic signed [CLIP_W-1:0] clip_r   [4];
  logic [2:0]               valid_r;
  logic                     vis_nxt, vis_r;
  logic [NUM_W-1:0]         num_x_nxt, num_y_nxt, den_nxt;
  logic [NUM_W-1:0]         num_x_r, num_y_r, den_r;
  logic signed [CLIP_W-1:0] cx, cy, cz, cw, ncw;

  // Stage 1: coefficient * coordinate, column 3 scaled by one
  always_comb begin
    logic signed [COEF_W-1:0] c0, c1, c2, c3;
    for (int r = 0; r < 4; r++) begin
      c0 = cfg.row[r][0*COEF_W +: COEF_W];
      c1 = cfg.row[r][1*COEF_W +: COEF_W];
      c2 = cfg.row[r][2*COEF_W +: COEF_W];
      c3 = cfg.row[r][3*COEF_W +: COEF_W];
      prod_nxt[r][0] = PROD_W'(c0) * PROD_W'(pos_x);
      prod_nxt[r][1] = PROD_W'(c1) * PROD_W'(pos_y);
      prod_nxt[r][2] = PROD_W'(c2) * PROD_W'(pos_z);
      prod_nxt[r][3] = PROD_W'(c3) <<< POS_FRAC_BITS;
    end
  end

  // Stage 2: sum each row
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      clip_nxt[r] = CLIP_W'(prod_r[r][0]) + CLIP_W'(prod_r[r][1]) +
                    CLIP_W'(prod_r[r][2]) + CLIP_W'(prod_r[r][3]);
    end
  end

  // Stage 3: clip volume test and divide operands
  assign cx  = clip_r[0];
  assign cy  = clip_r[1];
  assign cz  = clip_r[2];
  assign cw  = clip_r[3];
  assign ncw = -cw;

  always_comb begin
    vis_nxt = (cw > 0) &&
              (cx >= ncw) && (cx <= cw) &&
              (cy >= ncw) && (cy <= cw) &&
              (cz >= ncw) && (cz <= cw);
    num_x_nxt = NUM_W'(cx) + NUM_W'(cw);
    num_y_nxt = NUM_W'(cw) - NUM_W'(cy);
    den_nxt   = NUM_W'(cw) << 1;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[1:0], in_valid};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      clip_r  <= clip_nxt;
      vis_r   <= vis_nxt;
      num_x_r <= num_x_nxt;
      num_y_r <= num_y_nxt;
      den_r   <= den_nxt;
    end
  end

  assign out_valid = valid_r[2];
  assign visible   = vis_r;
  assign num_x     = num_x_r;
  assign num_y     = num_y_r;
  assign den       = den_r;

endmodule

// ----- sv/vpc_div.sv -----
// Viewport scale and pipelined restoring divider, one quotient bit a stage.
// Two lanes (x and y) share the denominator. Depends on vpc_pkg.
module vpc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic                          in_vis,
  input  logic [vpc_pkg::NUM_W-1:0]     num_x,
  input  logic [vpc_pkg::NUM_W-1:0]     num_y,
  input  logic [vpc_pkg::NUM_W-1:0]     den,
  input  vpc_pkg::cfg_t                 cfg,
  output logic                          out_valid,
  output logic                          out_vis,
  output logic [vpc_pkg::QUO_W-1:0]     quo_x,
  output logic [vpc_pkg::QUO_W-1:0]     quo_y
);
  import vpc_pkg::*;

  localparam int NST = QUO_W + 1;  // scale stage plus one per quotient bit

  logic [NST-1:0]   valid_r;
  logic             vis_r  [NST];
  logic [NUM_W-1:0] den_r  [NST];
  logic [NUM_W-1:0] rem_r  [NST][2];
  logic [QUO_W-1:0] low_r  [NST][2];
  logic [QUO_W-1:0] quo_r  [NST][2];
  logic [NUM_W-1:0] rem_nxt [NST][2];
  logic [QUO_W-1:0] low_nxt [NST][2];
  logic [QUO_W-1:0] quo_nxt [NST][2];
  logic [DVD_W-1:0] dvd [2];
  logic [SIZE_W-1:0] size_x, size_y;

  // Scale stage: numerator times size in 1/16 pixel
  assign size_x = {cfg.width, 4'b0};
  assign size_y = {cfg.height, 4'b0};
  assign dvd[0] = DVD_W'(num_x) * DVD_W'(size_x);
  assign dvd[1] = DVD_W'(num_y) * DVD_W'(size_y);

  always_comb begin
    logic [NUM_W:0] t;
    logic           ge;
    for (int l = 0; l < 2; l++) begin
      rem_nxt[0][l] = dvd[l][DVD_W-1 -: NUM_W];
      low_nxt[0][l] = dvd[l][QUO_W-1:0];
      quo_nxt[0][l] = '0;
      for (int k = 1; k < NST; k++) begin
        // Bring down one dividend bit, subtract where it fits
        t  = {rem_r[k-1][l], low_r[k-1][l][QUO_W-1]};
        ge = (t >= {1'b0, den_r[k-1]});
        rem_nxt[k][l] = ge ? NUM_W'(t - {1'b0, den_r[k-1]}) : t[NUM_W-1:0];
        low_nxt[k][l] = low_r[k-1][l] << 1;
        quo_nxt[k][l] = {quo_r[k-1][l][QUO_W-2:0], ge};
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[NST-2:0], in_valid};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      vis_r[0] <= in_vis;
      den_r[0] <= den;
      for (int k = 1; k < NST; k++) begin
        vis_r[k] <= vis_r[k-1];
        den_r[k] <= den_r[k-1];
      end
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign out_valid = valid_r[NST-1];
  assign out_vis   = vis_r[NST-1];
  assign quo_x     = quo_r[NST-1][0];
  assign quo_y     = quo_r[NST-1][1];

endmodule

// ----- sv/vertex_project_clip_viewport_top.sv -----
// Top level of the vertex projection, clip and viewport block.
// Depends on vpc_pkg, vpc_if, vpc_cfg, vpc_clip and vpc_div.
//
// Usage: each beat on in_ch carries one world point (signed x, y, z with
// POSITION_FRAC_BITS fraction bits). Each produces exactly one beat on
// out_ch: visible plus screen x and y in 1/16 pixel, zero when clipped.
// The matrix rows and viewport are written through the cfg_ APB port at
// byte address 8*index; write them only while no point is in flight.
// The pipeline registers are three for multiply, row sum and clip test,
// one for the viewport scale multiply, eighteen divider stages (one
// quotient bit each) and one output register. Throughput is one point a
// cycle while out_ch accepts. When out_ch stalls the whole pipeline holds
// in place and in_ch.ready drops until the output beat is taken; nothing
// is lost or repeated. Synchronous reset clears the configuration
// registers and the valid bits, which empties the pipe.
module vertex_project_clip_viewport_top #(
  parameter int POSITION_FRAC_BITS = vpc_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  vpc_in_if.sink                      in_ch,
  vpc_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [vpc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [vpc_pkg::ROW_W-1:0]   cfg_pwdata,
  output logic [vpc_pkg::ROW_W-1:0]   cfg_prdata,
  output logic                        cfg_pready
);
  import vpc_pkg::*;

  cfg_t              cfg;
  logic              en;
  logic              c_valid, c_vis, d_valid, d_vis;
  logic [NUM_W-1:0]  c_num_x, c_num_y, c_den;
  logic [QUO_W-1:0]  q_x, q_y;
  logic              out_valid_r, vis_r;
  logic [SCR_W-1:0]  sx_r, sy_r, sx_nxt, sy_nxt;
  logic [SCR_W:0]    sum_x, sum_y;

  vpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Advance the pipe whenever the output register is free or being taken
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  vpc_clip #(.POS_FRAC_BITS(POSITION_FRAC_BITS)) u_clip (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .pos_x     (in_ch.pos_x),
    .pos_y     (in_ch.pos_y),
    .pos_z     (in_ch.pos_z),
    .cfg       (cfg),
    .out_valid (c_valid),
    .visible   (c_vis),
    .num_x     (c_num_x),
    .num_y     (c_num_y),
    .den       (c_den)
  );

  vpc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_valid),
    .in_vis    (c_vis),
    .num_x     (c_num_x),
    .num_y     (c_num_y),
    .den       (c_den),
    .cfg       (cfg),
    .out_valid (d_valid),
    .out_vis   (d_vis),
    .quo_x     (q_x),
    .quo_y     (q_y)
  );

  // Add the origin, saturate, drop coordinates of clipped points
  assign sum_x = (SCR_W+1)'({cfg.left, 4'b0}) + (SCR_W+1)'(q_x);
  assign sum_y = (SCR_W+1)'({cfg.top, 4'b0})  + (SCR_W+1)'(q_y);

  always_comb begin
    sx_nxt = sum_x[SCR_W] ? SCREEN_MAX : sum_x[SCR_W-1:0];
    sy_nxt = sum_y[SCR_W] ? SCREEN_MAX : sum_y[SCR_W-1:0];
    if (!d_vis) begin
      sx_nxt = '0;
      sy_nxt = '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis_r <= d_vis;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.visible  = vis_r;
  assign out_ch.screen_x = sx_r;
  assign out_ch.screen_y = sy_r;

endmodule
